FILE: rtl/pcc_pkg.sv
package pcc_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned DIFF_W   = SAMPLE_W + 1;
    localparam int unsigned FRAC_W   = 8;

    // Widths of the shifted product terms and of their sum.
    localparam int unsigned P_W = 2 * SAMPLE_W - FRAC_W;          // 24
    localparam int unsigned I_W = SAMPLE_W + SUM_W - FRAC_W;      // 40
    localparam int unsigned D_W = SAMPLE_W + DIFF_W - FRAC_W;     // 25
    localparam int unsigned Y_W = I_W + 1;                        // 41

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_DRIVE_MAX = 3'd3,
        REG_DRIVE_MIN = 3'd4
    } t_reg_idx;

    localparam logic signed [SAMPLE_W-1:0] DRIVE_MAX_RST = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] DRIVE_MIN_RST = 16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gain_p;
        logic signed [SAMPLE_W-1:0] gain_i;
        logic signed [SAMPLE_W-1:0] gain_d;
        logic signed [SAMPLE_W-1:0] drive_max;
        logic signed [SAMPLE_W-1:0] drive_min;
    } t_cfg;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] error_sample;
        logic signed [SUM_W-1:0]    sum;
        logic signed [DIFF_W-1:0]   diff;
        logic                       diff_en;
    } t_item;

endpackage

FILE: rtl/pcc_if.sv
interface pcc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcc_pkg::SAMPLE_W-1:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface

interface pcc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcc_pkg::SAMPLE_W-1:0] drive;
    logic signed [pcc_pkg::SUM_W-1:0]    error_total;

    modport source (output valid, output drive, output error_total, input ready);
    modport sink   (input valid, input drive, input error_total, output ready);
endinterface

FILE: rtl/pcc_cfg.sv
module pcc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [pcc_pkg::PDATA_W-1:0]  pwdata,
    output logic [pcc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output pcc_pkg::t_cfg                o_cfg
);

    pcc_pkg::t_cfg r_cfg;
    pcc_pkg::t_cfg n_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;
    logic signed [pcc_pkg::SAMPLE_W-1:0] w_wdata;
    logic signed [pcc_pkg::SAMPLE_W-1:0] w_rdata;

    assign pready  = 1'b1;
    assign w_idx   = paddr[pcc_pkg::PADDR_W-1:2];
    assign w_wr    = psel && penable && pwrite;
    assign w_wdata = pwdata[pcc_pkg::SAMPLE_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                pcc_pkg::REG_GAIN_P:    n_cfg.gain_p    = w_wdata;
                pcc_pkg::REG_GAIN_I:    n_cfg.gain_i    = w_wdata;
                pcc_pkg::REG_GAIN_D:    n_cfg.gain_d    = w_wdata;
                pcc_pkg::REG_DRIVE_MAX: n_cfg.drive_max = w_wdata;
                pcc_pkg::REG_DRIVE_MIN: n_cfg.drive_min = w_wdata;
                default:                n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p    <= '0;
            r_cfg.gain_i    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.drive_max <= pcc_pkg::DRIVE_MAX_RST;
            r_cfg.drive_min <= pcc_pkg::DRIVE_MIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            pcc_pkg::REG_GAIN_P:    w_rdata = r_cfg.gain_p;
            pcc_pkg::REG_GAIN_I:    w_rdata = r_cfg.gain_i;
            pcc_pkg::REG_GAIN_D:    w_rdata = r_cfg.gain_d;
            pcc_pkg::REG_DRIVE_MAX: w_rdata = r_cfg.drive_max;
            pcc_pkg::REG_DRIVE_MIN: w_rdata = r_cfg.drive_min;
            default:                w_rdata = '0;
        endcase
    end

    assign prdata = pcc_pkg::PDATA_W'(w_rdata);
    assign o_cfg  = r_cfg;

endmodule

FILE: rtl/pcc_front.sv
module pcc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic signed [pcc_pkg::SAMPLE_W-1:0] i_error_sample,
    output logic                                o_in_ready,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output pcc_pkg::t_item                      o_item
);

    logic signed [pcc_pkg::SUM_W-1:0]    r_sum;
    logic signed [pcc_pkg::SAMPLE_W-1:0] r_prev;
    logic                                r_have_prev;
    logic signed [pcc_pkg::SUM_W:0]      w_sum_wide;
    logic signed [pcc_pkg::SUM_W-1:0]    n_sum;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Saturating accumulate: the two top bits differ only on overflow.
    assign w_sum_wide = (pcc_pkg::SUM_W+1)'(r_sum) + (pcc_pkg::SUM_W+1)'(i_error_sample);

    always_comb begin
        if (w_sum_wide[pcc_pkg::SUM_W] != w_sum_wide[pcc_pkg::SUM_W-1]) begin
            n_sum = w_sum_wide[pcc_pkg::SUM_W] ? {1'b1, {(pcc_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(pcc_pkg::SUM_W-1){1'b1}}};
        end else begin
            n_sum = w_sum_wide[pcc_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        o_item.error_sample = i_error_sample;
        o_item.sum          = n_sum;
        o_item.diff         = pcc_pkg::DIFF_W'(i_error_sample) - pcc_pkg::DIFF_W'(r_prev);
        o_item.diff_en      = r_have_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else if (o_push) begin
            r_sum       <= n_sum;
            r_prev      <= i_error_sample;
            r_have_prev <= 1'b1;
        end
    end

endmodule

FILE: rtl/pcc_queue.sv
module pcc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcc_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pcc_pkg::t_item o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    pcc_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/pcc_back.sv
module pcc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pcc_pkg::t_cfg                       i_cfg,
    input  logic                                i_item_valid,
    input  pcc_pkg::t_item                      i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [pcc_pkg::SAMPLE_W-1:0] o_drive,
    output logic signed [pcc_pkg::SUM_W-1:0]    o_error_total
);

    localparam int unsigned FW = pcc_pkg::FRAC_W;

    // Multiply stage
    logic                                 r_s1_valid;
    logic signed [pcc_pkg::P_W-1:0]       r_p;
    logic signed [pcc_pkg::I_W-1:0]       r_i;
    logic signed [pcc_pkg::D_W-1:0]       r_d;
    logic signed [pcc_pkg::SUM_W-1:0]     r_s1_sum;

    // Output register
    logic                                 r_out_valid;
    logic signed [pcc_pkg::SAMPLE_W-1:0]  r_drive;
    logic signed [pcc_pkg::SUM_W-1:0]     r_total;

    logic signed [2*pcc_pkg::SAMPLE_W-1:0]              w_prod_p;
    logic signed [pcc_pkg::SAMPLE_W+pcc_pkg::SUM_W-1:0] w_prod_i;
    logic signed [pcc_pkg::SAMPLE_W+pcc_pkg::DIFF_W-1:0] w_prod_d;
    logic signed [pcc_pkg::Y_W-1:0]       w_y;
    logic signed [pcc_pkg::Y_W-1:0]       w_max;
    logic signed [pcc_pkg::Y_W-1:0]       w_min;
    logic signed [pcc_pkg::SAMPLE_W-1:0]  n_drive;
    logic                                 w_out_load;
    logic                                 w_s1_load;

    assign w_out_load = !r_out_valid || i_ready;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign o_pop      = w_s1_load && i_item_valid;

    assign w_prod_p = i_cfg.gain_p * i_item.error_sample;
    assign w_prod_i = i_cfg.gain_i * i_item.sum;
    assign w_prod_d = i_cfg.gain_d * i_item.diff;

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_p      <= w_prod_p[2*pcc_pkg::SAMPLE_W-1:FW];
            r_i      <= w_prod_i[pcc_pkg::SAMPLE_W+pcc_pkg::SUM_W-1:FW];
            r_d      <= i_item.diff_en ? w_prod_d[pcc_pkg::SAMPLE_W+pcc_pkg::DIFF_W-1:FW]
                                       : '0;
            r_s1_sum <= i_item.sum;
        end
    end

    assign w_y   = pcc_pkg::Y_W'(r_p) + pcc_pkg::Y_W'(r_i) + pcc_pkg::Y_W'(r_d);
    assign w_max = pcc_pkg::Y_W'(i_cfg.drive_max);
    assign w_min = pcc_pkg::Y_W'(i_cfg.drive_min);

    // The upper bound wins when the bounds are inverted.
    always_comb begin
        if (w_y > w_max) begin
            n_drive = i_cfg.drive_max;
        end else if (w_y < w_min) begin
            n_drive = i_cfg.drive_min;
        end else begin
            n_drive = w_y[pcc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_drive <= n_drive;
            r_total <= r_s1_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= i_item_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_drive       = r_drive;
    assign o_error_total = r_total;

endmodule

FILE: rtl/pid_controller_clamped_top.sv
// PID controller with output clamp, Q8.8 fixed point.
//
// Input channel i_sample carries one signed error sample per transaction.
// Output channel o_result returns, in input order, the clamped drive
// (Kp*e + Ki*sum + Kd*(e - previous)) and the saturated 32-bit integral sum
// that includes this sample. Gains and clamp bounds sit behind an APB-style
// port at byte addresses 0x00 (gain_p), 0x04 (gain_i), 0x08 (gain_d), 0x0C
// (drive_max) and 0x10 (drive_min); write them only while nothing is in flight.
//
// Throughput is one transaction per cycle while results are taken. The front
// updates the integral and the previous error in the cycle of acceptance. An
// accepted sample is written into the queue, then goes from the queue through
// the multipliers into the stage registers and through add-and-clamp into the
// output register, where its result becomes valid.
//
// A synchronous active-low reset clears the integral, the previous error, the
// first-sample flag, the queue and the pipeline, and restores register reset
// values. When the receiver stalls the output register holds, the pipeline
// fills and the QUEUE_DEPTH-entry queue takes further samples before
// i_sample.ready drops; up to QUEUE_DEPTH + 2 transactions may be in flight.
module pid_controller_clamped_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pcc_in_if.sink                       i_sample,
    pcc_out_if.source                    o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [pcc_pkg::PDATA_W-1:0]  pwdata,
    output logic [pcc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    pcc_pkg::t_cfg  w_cfg;
    pcc_pkg::t_item w_push_item;
    pcc_pkg::t_item w_pop_item;
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_q_valid;

    // Register file for gains and clamp bounds.
    pcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Front: accepts a sample, updates the integral and forms the difference.
    pcc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_sample.valid),
        .i_error_sample (i_sample.error_sample),
        .o_in_ready     (i_sample.ready),
        .i_queue_full   (w_full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    // Decouples the front from back-pressure on the result channel.
    pcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_item)
    );

    // Back: multiplies, sums, clamps and holds the result for the receiver.
    pcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_item_valid  (w_q_valid),
        .i_item        (w_pop_item),
        .o_pop         (w_pop),
        .o_valid       (o_result.valid),
        .i_ready       (o_result.ready),
        .o_drive       (o_result.drive),
        .o_error_total (o_result.error_total)
    );

endmodule

FILE: rtl/pcc_checker.sv
module pcc_checker #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [pcc_pkg::SAMPLE_W-1:0] i_drive,
    input  logic signed [pcc_pkg::SUM_W-1:0]    i_error_total,
    input  logic                                i_pready
);

    localparam int unsigned CAP = QUEUE_DEPTH + 2;
    localparam int unsigned CW  = $clog2(CAP + 1);

    logic [CW-1:0] r_in_flight;
    logic          w_in_acc;
    logic          w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_in_flight <= r_in_flight + 1'b1;
        end else if (w_out_acc && !w_in_acc) begin
            r_in_flight <= r_in_flight - 1'b1;
        end
    end

    // A result may only appear for a sample that has been taken.
    a_no_phantom_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_in_flight != '0))
        else $error("result presented with no transaction in flight");

    // Queue plus two stages bound the number of outstanding transactions.
    a_in_flight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight <= CW'(CAP))
        else $error("more transactions in flight than the design can hold");

    // A full pipeline must push back on the input channel.
    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_flight == CW'(CAP)) |-> !i_in_ready)
        else $error("input accepted while all storage is occupied");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_drive) && $stable(i_error_total)))
        else $error("stalled result changed or was dropped");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("configuration port inserted a wait state");

endmodule

bind pid_controller_clamped_top pcc_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample.valid),
    .i_in_ready    (i_sample.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_drive       (o_result.drive),
    .i_error_total (o_result.error_total),
    .i_pready      (pready)
);
